/* design/ised_pkg.sv */
package ised_pkg;

   // Store geometry
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int POS_W   = 5;
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DATA_W  = 32;
   localparam int ACT_W   = 3;
   localparam int COUNT_W = 5;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 40;

   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CMP_W-1:0]  cmp_type;
   typedef logic [DATA_W-1:0] word_type;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_INS_TAIL  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_INS_AT    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DEL_END   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_DEL_AT    = 3'd5;
   localparam logic [ACT_W-1:0] ACT_READ_ALL  = 3'd6;

   // Cell operations
   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_INS  = 2'd1;
   localparam logic [1:0] CELL_DEL  = 2'd2;
   localparam logic [1:0] CELL_ROT  = 2'd3;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic [1:0] op;
      cnt_type    pos;
      cnt_type    cnt;
   } cell_cmd_type;

endpackage

/* design/ised_cell.sv */
module ised_cell (
   input  logic                  clock,
   input  ised_pkg::cnt_type     cell_index,
   input  ised_pkg::cell_cmd_type cmd,
   input  ised_pkg::word_type    ins_value,
   input  ised_pkg::word_type    left_data,
   input  ised_pkg::word_type    right_data,
   input  ised_pkg::word_type    head_data,
   output ised_pkg::word_type    entry_data
);

   ised_pkg::word_type entry_ff;
   ised_pkg::word_type entry_in;
   logic [ised_pkg::CNT_W:0] idx_next;
   logic [ised_pkg::CNT_W:0] cnt_ext;

   assign idx_next = {1'b0, cell_index} + 1'b1;
   assign cnt_ext  = {1'b0, cmd.cnt};

   // Pick this cell's next value from its own command decode
   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         ised_pkg::CELL_HOLD: entry_in = entry_ff;
         ised_pkg::CELL_INS: begin
            if (cell_index > cmd.pos) begin
               entry_in = left_data;
            end else if (cell_index == cmd.pos) begin
               entry_in = ins_value;
            end
         end
         ised_pkg::CELL_DEL: begin
            if (cell_index >= cmd.pos && idx_next < cnt_ext) begin
               entry_in = right_data;
            end
         end
         ised_pkg::CELL_ROT: begin
            if (idx_next < cnt_ext) begin
               entry_in = right_data;
            end else if (idx_next == cnt_ext) begin
               entry_in = head_data;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_data = entry_ff;

endmodule

/* design/ised_chain.sv */
module ised_chain (
   input  logic                   clock,
   input  ised_pkg::cell_cmd_type cmd,
   input  ised_pkg::word_type     ins_value,
   output ised_pkg::word_type     head_data
);

   ised_pkg::word_type cell_data [ised_pkg::DEPTH];

   // Row of cells, each wired to its neighbours (zero past either end) and to the head
   for (genvar g = 0; g < ised_pkg::DEPTH; g++) begin : g_cell
      ised_pkg::word_type left_data;
      ised_pkg::word_type right_data;

      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[g-1];
      end

      if (g == ised_pkg::DEPTH - 1) begin : g_end
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[g+1];
      end

      ised_cell u_cell (
         .clock      (clock),
         .cell_index (ised_pkg::cnt_type'(g)),
         .cmd        (cmd),
         .ins_value  (ins_value),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .entry_data (cell_data[g])
      );
   end

   assign head_data = cell_data[0];

endmodule

/* design/indexed_sequence_insert_delete.sv */
// Ordered store of up to DEPTH signed 32-bit entries held in a row of cells.
// Request channel req_*: one item per action (insert front/tail/at index,
// delete front/end/at index, read all). Result channel rsp_*: every edit
// gives one item with ok, count and empty_res, tlast high. Read-all streams
// the entries front to back, one item per entry, tlast on the final one; an
// empty store gives a single item with empty_res set.
// An edit result is registered and appears in the cycle after the request
// is taken. Every cell shifts in the same clock, so edits may follow back
// to back while results are drained. Read-all rotates the row by one entry
// per cycle while the receiver takes results, and the head cell feeds the
// result register.
// Reset clears the entry count and the handshake state; cell contents are
// left as they were and are never read beyond the count.
// When the receiver stalls, the result register holds and both the row and
// the request side wait until the item is taken.
module indexed_sequence_insert_delete (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [2:0] action, [34:3] value, [39:35] position
   input  logic [ised_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] ok, [5:1] count, [6] empty_res, [38:7] data, [39] zero
   output logic [ised_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                     state_ff, state_in;
   ised_pkg::cnt_type        count_ff, count_in;
   ised_pkg::cnt_type        remain_ff, remain_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     ok_ff, ok_in;
   ised_pkg::cnt_type        cnt_out_ff, cnt_out_in;
   logic                     empty_ff, empty_in;
   ised_pkg::word_type       data_ff, data_in;
   logic                     last_ff, last_in;

   logic [ised_pkg::ACT_W-1:0] action;
   ised_pkg::word_type       value;
   ised_pkg::cmp_type        position;
   ised_pkg::cmp_type        count_cmp;
   ised_pkg::cmp_type        pos_sel;
   logic                     slot_free;
   logic                     accept;
   logic                     is_ins, is_del, is_read;
   logic                     ins_ok, del_ok;
   ised_pkg::cell_cmd_type   cmd;
   ised_pkg::word_type       head_data;

   // Unpack the request item
   assign action   = req_tdata[2:0];
   assign value    = req_tdata[34:3];
   assign position = ised_pkg::cmp_type'(req_tdata[39:35]);
   assign count_cmp = ised_pkg::cmp_type'(count_ff);

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   // Decode the action and check its bounds
   always_comb begin
      is_ins  = 1'b0;
      is_del  = 1'b0;
      is_read = 1'b0;
      pos_sel = '0;
      unique case (action)
         ised_pkg::ACT_INS_FRONT: begin
            is_ins = 1'b1;
         end
         ised_pkg::ACT_INS_TAIL: begin
            is_ins  = 1'b1;
            pos_sel = count_cmp;
         end
         ised_pkg::ACT_INS_AT: begin
            is_ins  = 1'b1;
            pos_sel = position;
         end
         ised_pkg::ACT_DEL_FRONT: begin
            is_del = 1'b1;
         end
         ised_pkg::ACT_DEL_END: begin
            is_del  = 1'b1;
            pos_sel = count_cmp - 1'b1;
         end
         ised_pkg::ACT_DEL_AT: begin
            is_del  = 1'b1;
            pos_sel = position;
         end
         ised_pkg::ACT_READ_ALL: begin
            is_read = 1'b1;
         end
         default: begin
            is_ins = 1'b0;
         end
      endcase
   end

   assign ins_ok = is_ins && (count_ff < ised_pkg::cnt_type'(ised_pkg::DEPTH))
                   && (pos_sel <= count_cmp);
   assign del_ok = is_del && (count_ff != '0) && (pos_sel < count_cmp);

   // Command for the cell row
   always_comb begin
      cmd.op  = ised_pkg::CELL_HOLD;
      cmd.pos = pos_sel[ised_pkg::CNT_W-1:0];
      cmd.cnt = count_ff;
      if (state_ff == ST_READ && slot_free) begin
         cmd.op = ised_pkg::CELL_ROT;
      end else if (accept && ins_ok) begin
         cmd.op = ised_pkg::CELL_INS;
      end else if (accept && del_ok) begin
         cmd.op = ised_pkg::CELL_DEL;
      end
   end

   ised_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .ins_value (value),
      .head_data (head_data)
   );

   // Sequence edits and read-out, load the result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      cnt_out_in   = cnt_out_ff;
      empty_in     = empty_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_READ) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            ok_in        = 1'b1;
            cnt_out_in   = count_ff;
            empty_in     = 1'b0;
            data_in      = head_data;
            last_in      = (remain_ff == ised_pkg::cnt_type'(1));
            remain_in    = remain_ff - 1'b1;
            if (remain_ff == ised_pkg::cnt_type'(1)) begin
               state_in = ST_IDLE;
            end
         end
      end else if (accept) begin
         if (is_read && count_ff != '0) begin
            state_in  = ST_READ;
            remain_in = count_ff;
         end else begin
            if (ins_ok) begin
               count_in = count_ff + 1'b1;
            end else if (del_ok) begin
               count_in = count_ff - 1'b1;
            end
            rsp_valid_in = 1'b1;
            ok_in        = ins_ok || del_ok || is_read;
            cnt_out_in   = count_in;
            empty_in     = (count_in == '0);
            data_in      = '0;
            last_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff      <= ok_in;
      cnt_out_ff <= cnt_out_in;
      empty_ff   <= empty_in;
      data_ff    <= data_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, data_ff, empty_ff,
                        ised_pkg::COUNT_W'(cnt_out_ff), ok_ff};
   assign rsp_tlast  = last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ised_pkg::cnt_type'(ised_pkg::DEPTH))
      else $error("entry count above store depth");

   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !req_tready)
      else $error("request taken during read-out");

   a_read_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && slot_free && remain_ff == ised_pkg::cnt_type'(1))
      |=> (state_ff == ST_IDLE && rsp_tvalid && rsp_tlast))
      else $error("read-out did not close with a final item");

   a_read_count_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> $stable(count_ff))
      else $error("entry count changed during read-out");
`endif

endmodule

/* verif/ised_result_checker.sv */
module ised_result_checker
   import ised_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // [2:0] action, [34:3] value, [39:35] position
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [0] ok, [5:1] count, [6] empty_res, [38:7] data, [39] zero
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tlast,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic               ok;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
      word_type           data;
      logic               last;
   } result_type;

   // Shadow of the sequence store
   word_type   store_words [DEPTH];
   int         store_len;
   result_type awaited_results [$];

   // Queue one result, stamped with the current fill level
   function automatic void queue_result(bit ok, word_type v, bit last);
      result_type r;
      r.ok        = ok;
      r.count     = COUNT_W'(store_len);
      r.empty_res = (store_len == 0);
      r.data      = v;
      r.last      = last;
      awaited_results.push_back(r);
   endfunction

   // Open a gap at index at and place v there; refuse when full or past the tail
   function automatic bit store_insert(int at, word_type v);
      if (store_len >= DEPTH || at > store_len) return 1'b0;
      for (int i = store_len; i > at; i--) store_words[i] = store_words[i-1];
      store_words[at] = v;
      store_len++;
      return 1'b1;
   endfunction

   // Close the gap at index at; refuse when no entry sits there
   function automatic bit store_remove(int at);
      if (at >= store_len) return 1'b0;
      for (int i = at; i + 1 < store_len; i++) store_words[i] = store_words[i+1];
      store_len--;
      return 1'b1;
   endfunction

   // Apply one accepted item and queue the results it should give
   function automatic void apply_store_action(logic [ACT_W-1:0] act, word_type v,
                                              logic [POS_W-1:0] at);
      bit ok;
      case (act)
         ACT_INS_FRONT: ok = store_insert(0, v);
         ACT_INS_TAIL:  ok = store_insert(store_len, v);
         ACT_INS_AT:    ok = store_insert(int'(at), v);
         ACT_DEL_FRONT: ok = store_remove(0);
         ACT_DEL_END:   ok = (store_len != 0) ? store_remove(store_len - 1) : 1'b0;
         ACT_DEL_AT:    ok = store_remove(int'(at));
         ACT_READ_ALL: begin
            // stream front to back; an empty store still answers once
            if (store_len == 0)
               queue_result(1'b1, '0, 1'b1);
            else
               for (int i = 0; i < store_len; i++)
                  queue_result(1'b1, store_words[i], i + 1 == store_len);
            return;
         end
         default: ok = 1'b0;
      endcase
      queue_result(ok, '0, 1'b1);
   endfunction

   function automatic void note_failure(string what, logic [39:0] want, logic [39:0] got);
      if (fail_count < 10)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      fail_count++;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) note_failure(what, 40'(want), 40'(got));
   endfunction

   // Match results first so that a result never pairs with an item taken in the same cycle
   always @(posedge clock) begin
      result_type head;
      if (reset) begin
         store_len = 0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               note_failure("unexpected result", '0, {rsp_tlast, rsp_tdata[38:0]});
            end else begin
               head = awaited_results.pop_front();
               check_field("ok", 32'(head.ok), 32'(rsp_tdata[0]));
               check_field("count", 32'(head.count), 32'(rsp_tdata[5:1]));
               check_field("empty_res", 32'(head.empty_res), 32'(rsp_tdata[6]));
               check_field("data", head.data, rsp_tdata[38:7]);
               check_field("pad", '0, 32'(rsp_tdata[39]));
               check_field("last", 32'(head.last), 32'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            apply_store_action(req_tdata[2:0], req_tdata[34:3], req_tdata[39:35]);
      end
      pending <= awaited_results.size();
   end

endmodule

/* verif/tb_indexed_sequence_insert_delete.sv */
module tb_indexed_sequence_insert_delete;
   timeunit 1ns;
   timeprecision 1ps;

   import ised_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
   localparam word_type WORD_MAX     = 32'h7FFF_FFFF;
   localparam word_type WORD_MIN     = 32'h8000_0000;
   localparam int       ITEM_TARGET  = 330;
   localparam int       HOLD_AFTER   = 60;
   localparam int       HOLD_CYCLES  = 300;
   localparam int       DRAIN_CYCLES = 40;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // [2:0] action, [34:3] value, [39:35] position
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // [0] ok, [5:1] count, [6] empty_res, [38:7] data, [39] zero
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   int               fail_count;
   int               pending;

   // Rough fill level, used only to steer the random items
   int steer_len  = 0;
   int send_calm  = 0;
   int recv_calm  = 0;

   indexed_sequence_insert_delete DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   ised_result_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_indexed_sequence_insert_delete NOT OK");
      $finish;
   end

   // Mostly short gaps, a few long ones, and now and then a calm stretch with none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) calm = $urandom_range(20, 60);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one item, hold it until taken, then sometimes idle for a random gap
   task automatic put_item(logic [ACT_W-1:0] act, word_type v, logic [POS_W-1:0] at);
      int gap;
      req_tdata  <= {at, v, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      case (act)
         ACT_INS_FRONT, ACT_INS_TAIL: if (steer_len < DEPTH) steer_len++;
         ACT_INS_AT: if (steer_len < DEPTH && at <= steer_len) steer_len++;
         ACT_DEL_FRONT, ACT_DEL_END: if (steer_len > 0) steer_len--;
         ACT_DEL_AT: if (at < steer_len) steer_len--;
         default: ;
      endcase
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Pick an item biased towards filling or draining the store
   task automatic put_random_item(bit filling);
      int               r;
      logic [ACT_W-1:0] act;
      word_type         v;
      logic [POS_W-1:0] at;
      r = $urandom_range(0, 99);
      if (r < (filling ? 60 : 22)) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_INS_FRONT;
            1:       act = ACT_INS_TAIL;
            default: act = ACT_INS_AT;
         endcase
      end else if (r < 80) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_DEL_FRONT;
            1:       act = ACT_DEL_END;
            default: act = ACT_DEL_AT;
         endcase
      end else if (r < 95) begin
         act = ACT_READ_ALL;
      end else begin
         act = ACT_UNUSED;
      end
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0:       v = WORD_MAX;
            1:       v = WORD_MIN;
            2:       v = '0;
            default: v = '1;
         endcase
      end else begin
         v = $urandom;
      end
      // keep most indexes in range, with some anywhere in the field
      if ($urandom_range(0, 4) == 0)
         at = POS_W'($urandom_range(0, 31));
      else if (act == ACT_DEL_AT)
         at = POS_W'($urandom_range(0, (steer_len > 0) ? steer_len - 1 : 0));
      else
         at = POS_W'($urandom_range(0, steer_len));
      put_item(act, v, at);
   endtask

   // Receiver: random stalls plus one long hold-off to back the block up
   initial begin : receiver
      int gap;
      int taken;
      bit held;
      taken = 0;
      held  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = pick_gap(recv_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : stimulus
      bit filling;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty store: read-out gives one empty item, every delete refused, insert past the tail refused
      put_item(ACT_READ_ALL, '0, 5'd0);
      put_item(ACT_DEL_FRONT, '0, 5'd0);
      put_item(ACT_DEL_END, '0, 5'd0);
      put_item(ACT_DEL_AT, '0, 5'd0);
      put_item(ACT_INS_AT, 32'h1234_5678, 5'd1);
      // index equal to count appends
      put_item(ACT_INS_AT, '0, 5'd0);
      put_item(ACT_INS_FRONT, WORD_MAX, 5'd31);
      put_item(ACT_INS_TAIL, WORD_MIN, 5'd0);
      put_item(ACT_INS_AT, '1, 5'd3);
      put_item(ACT_INS_AT, 32'h5555_5555, 5'd1);
      put_item(ACT_INS_AT, 32'hAAAA_AAAA, 5'd31);
      put_item(ACT_READ_ALL, '0, 5'd0);
      // delete at or past count refused, then a valid one from the middle
      put_item(ACT_DEL_AT, '0, 5'd5);
      put_item(ACT_DEL_AT, '0, 5'd31);
      put_item(ACT_DEL_AT, '0, 5'd2);
      put_item(ACT_UNUSED, '1, 5'd31);
      put_item(ACT_DEL_FRONT, '0, 5'd0);
      put_item(ACT_DEL_END, '0, 5'd0);
      put_item(ACT_READ_ALL, '0, 5'd0);
      put_item(ACT_DEL_AT, '0, 5'd0);
      put_item(ACT_DEL_AT, '0, 5'd0);
      put_item(ACT_READ_ALL, '0, 5'd0);

      // swing between filling up to full and draining to empty
      filling = 1'b1;
      for (int n = 0; n < ITEM_TARGET; n++) begin
         if (filling && steer_len == DEPTH && $urandom_range(0, 3) == 0)
            filling = 1'b0;
         else if (!filling && steer_len == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
         put_random_item(filling);
      end
      req_tvalid <= 1'b0;

      // wait for every outstanding result, then watch for strays
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_indexed_sequence_insert_delete OK");
      else
         $display("tb_indexed_sequence_insert_delete NOT OK");
      $finish;
   end

endmodule
